[rtl/generational_handle_allocator_assert.svh]
// Assertion helpers for the allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Checked on every rising edge, suspended while reset is asserted.
`define GHA_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every rising edge, also during reset.
`define GHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/gha_pkg.sv]
`timescale 1ns / 1ps

package gha_pkg;

    localparam int IDX_W    = 10;
    localparam int VER_W    = 32;
    localparam int COMP_W   = 5;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 32;
    localparam int PADDR_W  = 3;

    localparam int SLOT_COUNT_DEF     = 1024;
    localparam int COMPONENT_BITS_DEF = 32;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 8;

    typedef logic [VER_W-1:0]    version_t;
    typedef logic [IDX_W-1:0]    index_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam version_t VERSION_DEAD = '1;
    localparam logic [CFG_W-1:0] CREATE_MASK_RESET = 32'd3;

    localparam logic [PADDR_W-1:0] ADDR_CREATE_MASK = 3'd0;

    localparam op_t OP_CREATE   = 3'd0;
    localparam op_t OP_DESTROY  = 3'd1;
    localparam op_t OP_ADD      = 3'd2;
    localparam op_t OP_REMOVE   = 3'd3;
    localparam op_t OP_HAS      = 3'd4;
    localparam op_t OP_VALIDATE = 3'd5;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_FULL    = 2'd2;

endpackage

[rtl/gha_ram.sv]
`timescale 1ns / 1ps

module gha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/generational_handle_allocator.sv]
// Channel   Direction  Words carried
// s_*       in         one operation: op, handle index, handle version, component
// m_*       out        one answer: result index, result version, has bit, status
// apb       in/out     create_mask register at byte address 0
//
// An operation is accepted and then executed: the accept cycle reads the version,
// mask and free stack memories, the execute state checks the handle and writes them back.
// After reset a clearing pass zeroes the version and mask stores, during which
// s_tready is low; configuration writes are taken as ever.
// A result waits in the output register; a new word is accepted meanwhile and
// holds in its execute cycle until the output register frees.
`timescale 1ns / 1ps

`include "generational_handle_allocator_assert.svh"

module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // handle_index [9:0], handle_version [41:10], component_index [46:42], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op [2:0], zero fill
    input  logic [S_TUSER_W-1:0] s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_index [9:0], result_version [41:10], has_bit [42], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status [1:0], zero fill
    output logic [M_TUSER_W-1:0] m_tuser,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [CFG_W-1:0]     pwdata,
    output logic [CFG_W-1:0]     prdata,
    output logic                 pready
);

    localparam int AW    = $clog2(SLOT_COUNT);
    localparam int CNT_W = AW + 1;
    localparam int STK_W = AW + VER_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] next_unused_reg, next_unused_next;
    logic [CFG_W-1:0] create_mask_reg;

    op_t            op_reg;
    index_t         idx_reg;
    version_t       ver_reg;
    logic [COMP_W-1:0] comp_reg;

    logic           m_valid_reg;
    index_t         r_idx_reg, r_idx_next;
    version_t       r_ver_reg, r_ver_next;
    logic           has_reg, has_next;
    status_t        status_reg, status_next;

    // Memory ports.
    logic                      ver_we, mask_we, stk_we, rd_en;
    logic [AW-1:0]             ver_waddr, mask_waddr, stk_waddr;
    version_t                  ver_wdata;
    logic [COMPONENT_BITS-1:0] mask_wdata;
    logic [STK_W-1:0]          stk_wdata;
    logic [AW-1:0]             slot_raddr, stk_raddr;
    version_t                  ver_rd;
    logic [COMPONENT_BITS-1:0] mask_rd;
    logic [STK_W-1:0]          stk_rd;

    logic                      accept, exec_go, handle_ok;
    logic [COMPONENT_BITS-1:0] bit_vec, cmask;
    logic [AW-1:0]             slot_addr, pop_slot;
    version_t                  pop_ver;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign exec_go  = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
    assign rd_en    = accept;

    assign slot_raddr = AW'(s_tdata[IDX_W-1:0]);
    assign stk_raddr  = AW'(free_count_reg - CNT_W'(1));

    gha_ram #(.WIDTH(VER_W), .DEPTH(SLOT_COUNT)) u_version_ram (
        .clk(aclk), .we(ver_we), .waddr(ver_waddr), .wdata(ver_wdata),
        .re(rd_en), .raddr(slot_raddr), .rdata(ver_rd)
    );

    gha_ram #(.WIDTH(COMPONENT_BITS), .DEPTH(SLOT_COUNT)) u_mask_ram (
        .clk(aclk), .we(mask_we), .waddr(mask_waddr), .wdata(mask_wdata),
        .re(rd_en), .raddr(slot_raddr), .rdata(mask_rd)
    );

    gha_ram #(.WIDTH(STK_W), .DEPTH(SLOT_COUNT)) u_free_stack_ram (
        .clk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(rd_en), .raddr(stk_raddr), .rdata(stk_rd)
    );

    always_comb begin
        for (int i = 0; i < COMPONENT_BITS; i++) begin
            bit_vec[i] = (32'(comp_reg) == i);
        end
    end

    assign cmask     = COMPONENT_BITS'(create_mask_reg);
    assign slot_addr = AW'(idx_reg);
    assign pop_slot  = stk_rd[STK_W-1:VER_W];
    assign pop_ver   = stk_rd[VER_W-1:0];
    assign handle_ok = (32'(idx_reg) < 32'(SLOT_COUNT)) && (ver_reg != VERSION_DEAD)
                       && (ver_rd == ver_reg);

    always_comb begin
        state_next       = state_reg;
        free_count_next  = free_count_reg;
        next_unused_next = next_unused_reg;
        ver_we     = 1'b0;
        ver_waddr  = slot_addr;
        ver_wdata  = ver_reg;
        mask_we    = 1'b0;
        mask_waddr = slot_addr;
        mask_wdata = mask_rd;
        stk_we     = 1'b0;
        stk_waddr  = AW'(free_count_reg);
        stk_wdata  = {slot_addr, ver_reg};
        r_idx_next  = idx_reg;
        r_ver_next  = ver_reg;
        has_next    = 1'b0;
        status_next = STATUS_OK;

        unique case (state_reg)
            ST_CLEAR: begin
                ver_we     = 1'b1;
                ver_waddr  = clr_cnt_reg;
                ver_wdata  = '0;
                mask_we    = 1'b1;
                mask_waddr = clr_cnt_reg;
                mask_wdata = '0;
                if (clr_cnt_reg == AW'(SLOT_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_CREATE: begin
                            if (free_count_reg != '0) begin
                                // Reuse the most recently freed slot one version up.
                                free_count_next = free_count_reg - CNT_W'(1);
                                ver_we     = 1'b1;
                                ver_waddr  = pop_slot;
                                ver_wdata  = pop_ver + VER_W'(1);
                                mask_we    = 1'b1;
                                mask_waddr = pop_slot;
                                mask_wdata = cmask;
                                r_idx_next = IDX_W'(pop_slot);
                                r_ver_next = pop_ver + VER_W'(1);
                            end else if (next_unused_reg < CNT_W'(SLOT_COUNT)) begin
                                next_unused_next = next_unused_reg + CNT_W'(1);
                                ver_we     = 1'b1;
                                ver_waddr  = AW'(next_unused_reg);
                                ver_wdata  = '0;
                                mask_we    = 1'b1;
                                mask_waddr = AW'(next_unused_reg);
                                mask_wdata = cmask;
                                r_idx_next = IDX_W'(next_unused_reg);
                                r_ver_next = '0;
                            end else begin
                                r_idx_next  = '0;
                                r_ver_next  = '0;
                                status_next = STATUS_FULL;
                            end
                        end
                        OP_DESTROY: begin
                            if (!handle_ok) begin
                                status_next = STATUS_INVALID;
                            end else begin
                                // A full stack loses the push, the slot still dies.
                                if (free_count_reg < CNT_W'(SLOT_COUNT)) begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + CNT_W'(1);
                                end
                                ver_we    = 1'b1;
                                ver_wdata = VERSION_DEAD;
                            end
                        end
                        OP_ADD, OP_REMOVE: begin
                            if (!handle_ok) begin
                                status_next = STATUS_INVALID;
                            end else begin
                                mask_we    = 1'b1;
                                mask_wdata = (op_reg == OP_ADD) ? (mask_rd | bit_vec)
                                                                : (mask_rd & ~bit_vec);
                            end
                        end
                        OP_HAS: begin
                            if (!handle_ok) begin
                                status_next = STATUS_INVALID;
                            end else begin
                                has_next = |(mask_rd & bit_vec);
                            end
                        end
                        OP_VALIDATE: begin
                            status_next = handle_ok ? STATUS_OK : STATUS_INVALID;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            free_count_reg  <= '0;
            next_unused_reg <= '0;
            m_valid_reg     <= 1'b0;
            create_mask_reg <= CREATE_MASK_RESET;
        end else begin
            state_reg       <= state_next;
            free_count_reg  <= free_count_next;
            next_unused_reg <= next_unused_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (exec_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && paddr == ADDR_CREATE_MASK) begin
                create_mask_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser[OP_W-1:0];
            idx_reg  <= s_tdata[IDX_W-1:0];
            ver_reg  <= s_tdata[IDX_W+VER_W-1:IDX_W];
            comp_reg <= s_tdata[IDX_W+VER_W+COMP_W-1:IDX_W+VER_W];
        end
        if (exec_go) begin
            r_idx_reg  <= r_idx_next;
            r_ver_reg  <= r_ver_next;
            has_reg    <= has_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - VER_W - 1){1'b0}}, has_reg, r_ver_reg, r_idx_reg};
    assign m_tuser  = {{(M_TUSER_W - STATUS_W){1'b0}}, status_reg};

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CREATE_MASK) ? create_mask_reg : '0;

    `GHA_ASSERT_RST(a_free_count_bound, aclk, aresetn, free_count_reg <= CNT_W'(SLOT_COUNT), "free stack count beyond slot count")
    `GHA_ASSERT_RST(a_unused_bound, aclk, aresetn, next_unused_reg <= CNT_W'(SLOT_COUNT), "never-used slot counter beyond slot count")
    `GHA_ASSERT_ALWAYS(a_no_accept_in_clear, aclk, (state_reg == ST_CLEAR) |-> !s_tready, "word accepted during clearing pass")
    `GHA_ASSERT_RST(a_accept_to_exec, aclk, aresetn, accept |=> (state_reg == ST_EXEC), "accepted word did not enter execute")
    `GHA_ASSERT_RST(a_unused_only_on_create, aclk, aresetn, !$stable(next_unused_reg) |-> $past(exec_go && op_reg == OP_CREATE), "never-used slot counter moved outside a create")

endmodule

[sim/gha_checker.sv]
`timescale 1ns / 1ps

module gha_checker
    import gha_pkg::*;
#(
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [CFG_W-1:0]     pwdata,
    input  logic [CFG_W-1:0]     prdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending
);

    localparam int VER_LO  = IDX_W;
    localparam int COMP_LO = IDX_W + VER_W;
    localparam int HAS_POS = IDX_W + VER_W;

    typedef struct packed {
        index_t   idx;
        version_t ver;
        logic     has;
        status_t  st;
    } answer_t;

    answer_t    answers_due[$];
    logic [CFG_W-1:0] create_mask_copy;
    version_t   slot_ver[SLOT_COUNT];
    logic [COMPONENT_BITS-1:0] slot_bits[SLOT_COUNT];
    index_t     free_idx[SLOT_COUNT];
    version_t   free_ver[SLOT_COUNT];
    int         free_top;
    int         next_fresh;
    int         errs;

    initial begin
        errs = 0;
        fail_count = 0;
        pending = 0;
    end

    function automatic logic handle_live(index_t idx, version_t ver);
        if (int'(idx) >= SLOT_COUNT)
            return 1'b0;
        return (ver != VERSION_DEAD) && (slot_ver[idx] == ver);
    endfunction

    // Applies one operation to the shadow allocator and returns its answer.
    function automatic answer_t allocate_or_check(op_t op, index_t idx, version_t ver,
                                                  logic [COMP_W-1:0] comp);
        answer_t a;
        logic live;
        logic [COMPONENT_BITS-1:0] bitsel;
        int slot;
        a.idx = idx;
        a.ver = ver;
        a.has = 1'b0;
        a.st  = STATUS_OK;
        live = handle_live(idx, ver);
        bitsel = (int'(comp) < COMPONENT_BITS) ? ({{(COMPONENT_BITS-1){1'b0}}, 1'b1} << comp)
                                               : '0;
        case (op)
            OP_CREATE: begin
                if (free_top > 0) begin
                    free_top--;
                    slot = int'(free_idx[free_top]);
                    if (slot >= SLOT_COUNT)
                        slot = 0;
                    slot_ver[slot]  = free_ver[free_top] + 1'b1;
                    slot_bits[slot] = create_mask_copy[COMPONENT_BITS-1:0];
                    a.idx = index_t'(slot);
                    a.ver = slot_ver[slot];
                end else if (next_fresh < SLOT_COUNT) begin
                    slot_ver[next_fresh]  = '0;
                    slot_bits[next_fresh] = create_mask_copy[COMPONENT_BITS-1:0];
                    a.idx = index_t'(next_fresh);
                    a.ver = '0;
                    next_fresh++;
                end else begin
                    a.idx = '0;
                    a.ver = '0;
                    a.st  = STATUS_FULL;
                end
            end
            OP_DESTROY: begin
                if (!live) begin
                    a.st = STATUS_INVALID;
                end else begin
                    // A full stack still kills the slot but loses the push.
                    if (free_top < SLOT_COUNT) begin
                        free_idx[free_top] = idx;
                        free_ver[free_top] = ver;
                        free_top++;
                    end
                    slot_ver[idx] = VERSION_DEAD;
                end
            end
            OP_ADD: begin
                if (!live)
                    a.st = STATUS_INVALID;
                else
                    slot_bits[idx] = slot_bits[idx] | bitsel;
            end
            OP_REMOVE: begin
                if (!live)
                    a.st = STATUS_INVALID;
                else
                    slot_bits[idx] = slot_bits[idx] & ~bitsel;
            end
            OP_HAS: begin
                if (!live)
                    a.st = STATUS_INVALID;
                else
                    a.has = |(slot_bits[idx] & bitsel);
            end
            OP_VALIDATE: begin
                a.st = live ? STATUS_OK : STATUS_INVALID;
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        if (!aresetn) begin
            create_mask_copy = CREATE_MASK_RESET;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_ver[i]  = '0;
                slot_bits[i] = '0;
            end
            free_top   = 0;
            next_fresh = 0;
            answers_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.idx = m_tdata[IDX_W-1:0];
                got.ver = m_tdata[VER_LO +: VER_W];
                got.has = m_tdata[HAS_POS];
                got.st  = m_tuser[STATUS_W-1:0];
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result word idx=%0d ver=%h has=%b status=%0d",
                             $time, got.idx, got.ver, got.has, got.st);
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.idx !== want.idx) begin
                        $display("%0t: result_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                        errs++;
                    end
                    if (got.ver !== want.ver) begin
                        $display("%0t: result_version expected %h actual %h",
                                 $time, want.ver, got.ver);
                        errs++;
                    end
                    if (got.has !== want.has) begin
                        $display("%0t: has_bit expected %b actual %b",
                                 $time, want.has, got.has);
                        errs++;
                    end
                    if (got.st !== want.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, got.st);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                answers_due.insert(answers_due.size(),
                                   allocate_or_check(s_tuser[OP_W-1:0], s_tdata[IDX_W-1:0],
                                                     s_tdata[VER_LO +: VER_W],
                                                     s_tdata[COMP_LO +: COMP_W]));
        end
        if (psel && penable && pready && paddr == ADDR_CREATE_MASK) begin
            if (pwrite) begin
                create_mask_copy = pwdata;
            end else if (prdata !== create_mask_copy) begin
                $display("%0t: create_mask readback expected %h actual %h",
                         $time, create_mask_copy, prdata);
                errs++;
            end
        end
        pending    <= answers_due.size();
        fail_count <= errs;
    end

endmodule

[sim/tb_generational_handle_allocator.sv]
`timescale 1ns / 1ps

module tb_generational_handle_allocator;
    import gha_pkg::*;

    localparam op_t OP_SPARE_A = 3'd6;
    localparam op_t OP_SPARE_B = 3'd7;
    localparam int  STALL_LIMIT = 5000;
    localparam int  HOLD_CYCLES = 300;
    localparam int  POOL_SIZE   = 64;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [CFG_W-1:0]     pwdata;
    logic [CFG_W-1:0]     prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int stall_cycles;

    // Handles seen in answers, used to aim operations at live slots.
    index_t   pool_idx[POOL_SIZE];
    version_t pool_ver[POOL_SIZE];
    int       pool_n;

    generational_handle_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gha_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tuser[STATUS_W-1:0] == STATUS_OK) begin
            if (pool_n < POOL_SIZE) begin
                pool_idx[pool_n] = m_tdata[IDX_W-1:0];
                pool_ver[pool_n] = m_tdata[IDX_W +: VER_W];
                pool_n++;
            end else begin
                int k;
                k = $urandom_range(POOL_SIZE - 1);
                pool_idx[k] = m_tdata[IDX_W-1:0];
                pool_ver[k] = m_tdata[IDX_W +: VER_W];
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge aclk);
        end
    end

    task automatic send_word(op_t op, index_t idx, version_t ver, logic [COMP_W-1:0] comp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, comp, ver, idx};
        s_tuser  <= {{(S_TUSER_W-OP_W){1'b0}}, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_random_word(int create_pct);
        op_t op;
        index_t idx;
        version_t ver;
        int r;
        int k;
        r = $urandom_range(99);
        if (r < create_pct) begin
            op = OP_CREATE;
        end else begin
            r = $urandom_range(99);
            if (r < 20)      op = OP_DESTROY;
            else if (r < 38) op = OP_ADD;
            else if (r < 54) op = OP_REMOVE;
            else if (r < 74) op = OP_HAS;
            else if (r < 95) op = OP_VALIDATE;
            else if (r < 97) op = OP_SPARE_A;
            else             op = OP_SPARE_B;
        end
        r = $urandom_range(99);
        if (pool_n > 0 && r < 65) begin
            k = $urandom_range(pool_n - 1);
            idx = pool_idx[k];
            ver = pool_ver[k];
            // Near-miss versions exercise the stale-handle check.
            if (r >= 57)
                ver = $urandom_range(1) ? ver + 1'b1 : ver - 1'b1;
        end else if (r < 80) begin
            idx = index_t'($urandom_range(1023));
            ver = '0;
        end else if (r < 88) begin
            idx = index_t'($urandom_range(1023));
            ver = VERSION_DEAD;
        end else begin
            idx = index_t'($urandom_range(1023));
            ver = $urandom;
        end
        send_word(op, idx, ver, COMP_W'($urandom_range(31)));
    endtask

    task automatic apb_access(logic wr, logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_CREATE_MASK;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Every operation answers, so an empty queue plus a short pause means idle.
    task automatic drain_and_set_mask(logic [CFG_W-1:0] mask);
        while (pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        apb_access(1'b1, mask);
        apb_access(1'b0, '0);
    endtask

    task automatic run_random(int count, int create_pct);
        for (int i = 0; i < count; i++)
            send_random_word(create_pct);
        s_tvalid <= 1'b0;
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        hold_req = 1'b0;
        pool_n   = 0;
        stall_cycles = 0;
        tx_idle_pct = 32;
        rx_idle_pct = 76;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_access(1'b0, '0);

        // Directed: fresh slots, component bits, stale and never-created handles.
        send_word(OP_CREATE,   10'd0,    32'd0,        5'd0);
        send_word(OP_CREATE,   10'd0,    32'd0,        5'd0);
        send_word(OP_CREATE,   10'd0,    32'd0,        5'd0);
        send_word(OP_HAS,      10'd0,    32'd0,        5'd0);
        send_word(OP_HAS,      10'd0,    32'd0,        5'd2);
        send_word(OP_ADD,      10'd0,    32'd0,        5'd31);
        send_word(OP_HAS,      10'd0,    32'd0,        5'd31);
        send_word(OP_REMOVE,   10'd0,    32'd0,        5'd0);
        send_word(OP_HAS,      10'd0,    32'd0,        5'd0);
        send_word(OP_VALIDATE, 10'd1,    32'd0,        5'd0);
        send_word(OP_VALIDATE, 10'd1,    32'd5,        5'd0);
        send_word(OP_VALIDATE, 10'd1023, 32'd0,        5'd0);
        send_word(OP_VALIDATE, 10'd1023, VERSION_DEAD, 5'd0);
        send_word(OP_DESTROY,  10'd1,    32'd0,        5'd0);
        send_word(OP_DESTROY,  10'd1,    32'd0,        5'd0);
        send_word(OP_HAS,      10'd1,    32'd0,        5'd1);
        send_word(OP_CREATE,   10'd1023, VERSION_DEAD, 5'd31);
        send_word(OP_VALIDATE, 10'd1,    32'd1,        5'd0);
        send_word(OP_ADD,      10'd1023, 32'd0,        5'd31);
        send_word(OP_HAS,      10'd1023, 32'd0,        5'd31);
        send_word(OP_SPARE_A,  10'd1023, VERSION_DEAD, 5'd31);
        send_word(OP_SPARE_B,  10'd0,    32'd0,        5'd0);
        send_word(OP_REMOVE,   10'd1023, 32'd5,        5'd3);
        s_tvalid <= 1'b0;

        drain_and_set_mask($urandom);
        run_random(200, 30);

        tx_idle_pct = 76;
        rx_idle_pct = 32;
        drain_and_set_mask('1);
        run_random(200, 30);

        // Create-heavy burst with no idling runs the slots out; the receiver
        // holds off first so the block backs up into its input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_and_set_mask('0);
        hold_req = 1'b1;
        run_random(1100, 92);

        drain_and_set_mask($urandom);
        run_random(150, 25);

        while (pending != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
